[sv/dpde_pkg.sv]
package dpde_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DW        = 32;   // signed data words
  localparam int unsigned CW        = 31;   // unsigned register and input magnitudes
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_CUTOFF = 3'd1,
    CFG_DISS   = 3'd2,
    CFG_NOISE  = 3'd3,
    CFG_ISDT   = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    MODE_FIX_DISS  = 1'b0,
    MODE_FIX_NOISE = 1'b1
  } mode_e;

  typedef struct packed {
    logic signed [DW-1:0] sep_x;
    logic signed [DW-1:0] sep_y;
    logic signed [DW-1:0] sep_z;
    logic signed [DW-1:0] rel_vel_x;
    logic signed [DW-1:0] rel_vel_y;
    logic signed [DW-1:0] rel_vel_z;
    logic [CW-1:0]        weight;
    logic [CW-1:0]        inv_temp_first;
    logic [CW-1:0]        inv_temp_second;
    logic signed [DW-1:0] gauss;
    logic                 acts_first;
    logic                 acts_second;
  } pair_in_t;

  typedef struct packed {
    logic signed [DW-1:0] force_x;
    logic signed [DW-1:0] force_y;
    logic signed [DW-1:0] force_z;
    logic signed [DW-1:0] energy_change;
    logic                 in_range;
    logic                 apply_first;
    logic                 apply_second;
  } pair_out_t;

  function automatic logic signed [DW-1:0] sat64(input logic signed [2*DW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // unsigned value clipped to the positive signed range
  function automatic logic signed [DW-1:0] satu64(input logic [2*DW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > 64'd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // fixed-point product, floor rounding, saturated
  function automatic logic signed [DW-1:0] fmul(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [2*DW-1:0] p;
    p = 64'(a) * 64'(b);
    return sat64(p >>> FRAC_BITS);
  endfunction

  function automatic logic [DW-1:0] mag32(input logic signed [DW-1:0] v);
    logic [DW-1:0] r;
    r = v[DW-1] ? DW'(-v) : DW'(v);
    return r;
  endfunction

endpackage

[sv/dpde_sqrt.sv]
// Pipelined floor square root, one root bit per stage.
module dpde_sqrt import dpde_pkg::*; #(
  parameter int unsigned RES_W = 32
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [2*RES_W-1:0]   rad_i,
  output logic [RES_W-1:0]     root_o
);

  localparam int unsigned IN_W = 2 * RES_W;

  logic [IN_W-1:0]  x_q   [1:RES_W];
  logic [RES_W-1:0] rem_q [1:RES_W];
  logic [RES_W-1:0] r_q   [1:RES_W];

  for (genvar k = 0; k < RES_W; k++) begin : g_stage
    logic [IN_W-1:0]    x_c;
    logic [RES_W-1:0]   rem_c;
    logic [RES_W-1:0]   r_c;
    logic [RES_W+1:0]   rem_sh;
    logic [RES_W+1:0]   trial;
    logic [RES_W+1:0]   diff;
    logic               ge;

    if (k == 0) begin : g_first
      assign x_c   = rad_i;
      assign rem_c = '0;
      assign r_c   = '0;
    end else begin : g_next
      assign x_c   = x_q[k];
      assign rem_c = rem_q[k];
      assign r_c   = r_q[k];
    end

    assign rem_sh = {rem_c, x_c[IN_W-1 -: 2]};
    assign trial  = {r_c, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1] <= {r_c[RES_W-2:0], ge};
      end
    end

    if (k < RES_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[k+1]   <= x_c << 2;
          rem_q[k+1] <= ge ? diff[RES_W-1:0] : rem_sh[RES_W-1:0];
        end
      end
    end
  end

  assign root_o = r_q[RES_W];

endmodule

[sv/dpde_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// A quotient that does not fit in Q_W bits comes out as all ones.
module dpde_div import dpde_pkg::*; #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned Q_W   = 17
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  localparam int unsigned HI_W  = NUM_W - Q_W;
  localparam int unsigned CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [HI_W-1:0]  hi;
  logic             ovf0;

  logic [Q_W-1:0]   lo_q  [1:Q_W];
  logic [DEN_W-1:0] rem_q [1:Q_W];
  logic [DEN_W-1:0] den_q [1:Q_W];
  logic [Q_W-1:0]   q_q   [1:Q_W];
  logic             ovf_q [1:Q_W];

  assign hi   = num_i[NUM_W-1:Q_W];
  assign ovf0 = CMP_W'(hi) >= CMP_W'(den_i);

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [Q_W-1:0]   lo_c;
    logic [DEN_W-1:0] rem_c;
    logic [DEN_W-1:0] den_c;
    logic [Q_W-1:0]   q_c;
    logic             ovf_c;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign lo_c  = num_i[Q_W-1:0];
      assign rem_c = ovf0 ? '0 : DEN_W'(hi);
      assign den_c = den_i;
      assign q_c   = '0;
      assign ovf_c = ovf0;
    end else begin : g_next
      assign lo_c  = lo_q[k];
      assign rem_c = rem_q[k];
      assign den_c = den_q[k];
      assign q_c   = q_q[k];
      assign ovf_c = ovf_q[k];
    end

    assign rem_sh = {rem_c, lo_c[Q_W-1]};
    assign ge     = rem_sh >= {1'b0, den_c};
    assign diff   = rem_sh - {1'b0, den_c};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k+1]   <= {q_c[Q_W-2:0], ge};
        ovf_q[k+1] <= ovf_c;
      end
    end

    if (k < Q_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          lo_q[k+1]  <= lo_c << 1;
          rem_q[k+1] <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          den_q[k+1] <= den_c;
        end
      end
    end
  end

  assign quo_o = ovf_q[Q_W] ? '1 : q_q[Q_W];

endmodule

[sv/dpde_pair_force.sv]
// DPD energy-conserving pair force engine. One particle pair per beat goes in and one
// result beat comes out for it; a new pair is taken every cycle unless the input stalls.
// The noise path is the longest: a 31-stage divider for sigma^2 = 4D/(bf+bs) followed
// by a 31-stage square root, both one bit per stage; the distance root (32 stages) and
// the direction dividers (17 stages) run alongside it. When the output beat is stalled
// the whole pipeline holds, and the input stalls only while a finished beat waits. Values
// are Q16.16, products floor-rounded and saturated. The force is the one on the first
// particle; the second one gets its negation. Configuration must be written while idle.
module dpde_pair_force import dpde_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pair_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pair_out_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CW-1:0]        cfg_data_i
);

  localparam int unsigned ST_SUM  = 2;
  localparam int unsigned ST_DIST = ST_SUM + DW;
  localparam int unsigned EQ_W    = FRAC_BITS + 1;
  localparam int unsigned ST_E    = ST_DIST + EQ_W;
  localparam int unsigned ST_EP   = ST_E + 1;
  localparam int unsigned ST_EV   = ST_EP + 1;
  localparam int unsigned ST_NSQ  = 1 + CW;
  localparam int unsigned ST_RAD  = ST_NSQ + 1;
  localparam int unsigned ST_ROOT = ST_RAD + CW;
  localparam int unsigned ST_X1   = ST_ROOT + 1;
  localparam int unsigned ST_X2   = ST_ROOT + 2;
  localparam int unsigned ST_X3   = ST_ROOT + 3;
  localparam int unsigned ST_X4   = ST_ROOT + 4;
  localparam int unsigned ST_X5   = ST_ROOT + 5;
  localparam int unsigned NS      = ST_ROOT + 6;
  localparam int unsigned NUM_NW  = CW + 2 + FRAC_BITS;

  // configuration
  mode_e         mode_q;
  logic [CW-1:0] cutoff_q, diss_q, noise_q, isdt_q;
  logic          mode1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_FIX_DISS;
      cutoff_q <= CW'(1 << FRAC_BITS);
      diss_q   <= CW'(1 << FRAC_BITS);
      noise_q  <= CW'(1 << FRAC_BITS);
      isdt_q   <= CW'(1 << FRAC_BITS);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:   mode_q   <= mode_e'(cfg_data_i[0]);
        CFG_CUTOFF: cutoff_q <= cfg_data_i;
        CFG_DISS:   diss_q   <= cfg_data_i;
        CFG_NOISE:  noise_q  <= cfg_data_i;
        CFG_ISDT:   isdt_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign mode1 = (mode_q == MODE_FIX_NOISE);

  // pipeline control: the whole pipe holds while the output beat is stalled
  logic [NS:1] vld_q;
  logic        en;

  assign en          = !(vld_q[NS] && out_stall_i);
  assign in_stall_o  = vld_q[NS] && out_stall_i;
  assign out_valid_o = vld_q[NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-1:1], in_valid_i};
    end
  end

  // input beat travels alongside the arithmetic
  pair_in_t side_q [1:NS-1];
  logic     inr_q  [ST_SUM:NS-1];

  always_ff @(posedge clk_i) begin
    if (en) side_q[1] <= in_data_i;
  end

  for (genvar k = 2; k < NS; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) side_q[k] <= side_q[k-1];
    end
  end

  for (genvar k = ST_SUM + 1; k < NS; k++) begin : g_inr
    always_ff @(posedge clk_i) begin
      if (en) inr_q[k] <= inr_q[k-1];
    end
  end

  // squared length and range check
  logic [DW-1:0]     m_in [3];
  logic [2*DW-1:0]   sq_q [3];
  logic [2*CW-1:0]   cut2_q;
  logic [2*DW-1:0]   sum1;
  logic [2*DW-1:0]   sumsq_q;

  assign m_in[0] = mag32(in_data_i.sep_x);
  assign m_in[1] = mag32(in_data_i.sep_y);
  assign m_in[2] = mag32(in_data_i.sep_z);
  assign sum1    = sq_q[0] + sq_q[1] + sq_q[2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq_q[i] <= 64'(m_in[i]) * 64'(m_in[i]);
      cut2_q        <= (2*CW)'(cutoff_q) * (2*CW)'(cutoff_q);
      sumsq_q       <= sum1;
      inr_q[ST_SUM] <= sum1 < (2*DW)'(cut2_q);
    end
  end

  // distance and unit direction
  logic [DW-1:0]          dist_len;
  logic [EQ_W-1:0]        eq [3];
  logic signed [DW-1:0]   sep_d [3];
  logic signed [DW-1:0]   sep_e [3];
  logic signed [DW-1:0]   vel_e [3];
  logic signed [DW-1:0]   e_val [3];
  logic                   zero_e;

  dpde_sqrt #(.RES_W(DW)) u_dist (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sumsq_q),
    .root_o (dist_len)
  );

  assign sep_d[0] = side_q[ST_DIST].sep_x;
  assign sep_d[1] = side_q[ST_DIST].sep_y;
  assign sep_d[2] = side_q[ST_DIST].sep_z;
  assign sep_e[0] = side_q[ST_E].sep_x;
  assign sep_e[1] = side_q[ST_E].sep_y;
  assign sep_e[2] = side_q[ST_E].sep_z;
  assign vel_e[0] = side_q[ST_E].rel_vel_x;
  assign vel_e[1] = side_q[ST_E].rel_vel_y;
  assign vel_e[2] = side_q[ST_E].rel_vel_z;

  // zero separation: direction forced to zero
  assign zero_e = (sep_e[0] == '0) && (sep_e[1] == '0) && (sep_e[2] == '0);

  for (genvar i = 0; i < 3; i++) begin : g_dir
    logic [DW-1:0] e_mag;

    dpde_div #(.NUM_W(DW + FRAC_BITS), .DEN_W(DW), .Q_W(EQ_W)) u_ediv (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ({mag32(sep_d[i]), {FRAC_BITS{1'b0}}}),
      .den_i (dist_len),
      .quo_o (eq[i])
    );

    assign e_mag    = zero_e ? '0 : DW'(eq[i]);
    assign e_val[i] = sep_e[i][DW-1] ? -signed'(e_mag) : signed'(e_mag);
  end

  logic signed [DW-1:0]   e_q  [ST_EP:NS-1][3];
  logic signed [2*DW-1:0] ep_q [3];
  logic signed [2*DW-1:0] ev_sum;
  logic signed [DW-1:0]   ev_q [ST_EV:ST_X4];

  assign ev_sum = ep_q[0] + ep_q[1] + ep_q[2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e_q[ST_EP][i] <= e_val[i];
        ep_q[i]       <= 64'(e_val[i]) * 64'(vel_e[i]);
      end
      ev_q[ST_EV] <= sat64(ev_sum >>> FRAC_BITS);
    end
  end

  for (genvar k = ST_EP + 1; k < NS; k++) begin : g_edly
    always_ff @(posedge clk_i) begin
      if (en) e_q[k] <= e_q[k-1];
    end
  end

  for (genvar k = ST_EV + 1; k <= ST_X4; k++) begin : g_evdly
    always_ff @(posedge clk_i) begin
      if (en) ev_q[k] <= ev_q[k-1];
    end
  end

  // noise path: sigma^2 by division, then the root of the noise weight
  logic [DW-1:0]         bsum1;
  logic [CW-1:0]         nsq;
  logic [2*CW-1:0]       prod_ns;
  logic [2*CW-1:0]       rad_q;
  logic [CW-1:0]         root;
  logic signed [DW-1:0]  b0_q [ST_RAD:ST_X1];

  assign bsum1 = DW'(side_q[1].inv_temp_first) + DW'(side_q[1].inv_temp_second);

  // zero temperature sum overflows the divider and saturates
  dpde_div #(.NUM_W(NUM_NW), .DEN_W(DW), .Q_W(CW)) u_ndiv (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({diss_q, 2'b00, {FRAC_BITS{1'b0}}}),
    .den_i (bsum1),
    .quo_o (nsq)
  );

  assign prod_ns = (2*CW)'(nsq) * (2*CW)'(side_q[ST_NSQ].weight);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q        <= mode1 ? (2*CW)'({side_q[ST_NSQ].weight, {FRAC_BITS{1'b0}}}) : prod_ns;
      b0_q[ST_RAD] <= satu64((2*DW)'(prod_ns) >> FRAC_BITS);
    end
  end

  for (genvar k = ST_RAD + 1; k <= ST_X1; k++) begin : g_b0dly
    always_ff @(posedge clk_i) begin
      if (en) b0_q[k] <= b0_q[k-1];
    end
  end

  dpde_sqrt #(.RES_W(CW)) u_nroot (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (root)
  );

  // force and energy chain, one product per lane per stage
  logic signed [DW-1:0]   noise_s, isdt_s, root_s, w_x1, w_x2;
  logic [DW-1:0]          bsum_x1;
  logic [2*DW-1:0]        dprod;
  logic signed [2*DW-1:0] fdp;
  logic signed [DW-1:0]   x1_q, n2_q, p2_q, diss2_q, b2_q;
  logic [CW-1:0]          root1_q;
  logic signed [DW-1:0]   fn3_q, t3_q, b3_q;
  logic signed [DW-1:0]   fd4_q, fn4_q, b4_q;
  logic signed [DW-1:0]   a5_q, c5_q, fs5_q, b5_q;
  logic signed [2*DW-1:0] fe_sum;
  pair_out_t              out_q;

  assign noise_s = signed'({1'b0, noise_q});
  assign isdt_s  = signed'({1'b0, isdt_q});
  assign root_s  = signed'({1'b0, root});
  assign w_x1    = signed'({1'b0, side_q[ST_X1].weight});
  assign w_x2    = signed'({1'b0, side_q[ST_X2].weight});
  assign bsum_x1 = DW'(side_q[ST_X1].inv_temp_first) + DW'(side_q[ST_X1].inv_temp_second);
  assign dprod   = (2*DW)'(n2_q[CW-1:0]) * (2*DW)'(bsum_x1);
  assign fdp     = 64'(t3_q) * 64'(ev_q[ST_X3]);
  assign fe_sum  = -64'(a5_q) - 64'(b5_q) - 64'(c5_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q    <= fmul(side_q[ST_ROOT].gauss, mode1 ? noise_s : root_s);
      n2_q    <= fmul(noise_s, noise_s);
      root1_q <= root;

      p2_q    <= fmul(x1_q, mode1 ? signed'({1'b0, root1_q}) : isdt_s);
      diss2_q <= mode1 ? satu64(dprod >> (FRAC_BITS + 2)) : signed'({1'b0, diss_q});
      b2_q    <= mode1 ? fmul(n2_q, w_x1) : b0_q[ST_X1];

      fn3_q   <= mode1 ? fmul(p2_q, isdt_s) : p2_q;
      t3_q    <= fmul(diss2_q, w_x2);
      b3_q    <= b2_q;

      fd4_q   <= sat64((-fdp) >>> FRAC_BITS);
      fn4_q   <= fn3_q;
      b4_q    <= b3_q;

      a5_q    <= fmul(fd4_q, ev_q[ST_X4]);
      c5_q    <= fmul(fn4_q, ev_q[ST_X4]);
      fs5_q   <= sat64(64'(fd4_q) + 64'(fn4_q));
      b5_q    <= b4_q;

      if (inr_q[ST_X5]) begin
        out_q.force_x       <= fmul(fs5_q, e_q[ST_X5][0]);
        out_q.force_y       <= fmul(fs5_q, e_q[ST_X5][1]);
        out_q.force_z       <= fmul(fs5_q, e_q[ST_X5][2]);
        out_q.energy_change <= sat64(fe_sum >>> 1);
      end else begin
        out_q.force_x       <= '0;
        out_q.force_y       <= '0;
        out_q.force_z       <= '0;
        out_q.energy_change <= '0;
      end
      out_q.in_range     <= inr_q[ST_X5];
      out_q.apply_first  <= inr_q[ST_X5] && side_q[ST_X5].acts_first;
      out_q.apply_second <= inr_q[ST_X5] && side_q[ST_X5].acts_second;
    end
  end

  assign out_data_o = out_q;

  // out of range beats carry no force and no energy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_range |->
      out_data_o.force_x == '0 && out_data_o.force_y == '0 &&
      out_data_o.force_z == '0 && out_data_o.energy_change == '0 &&
      !out_data_o.apply_first && !out_data_o.apply_second)
    else $error("out of range beat has nonzero payload");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[NS-1]))
    else $error("result beat without a pair behind it");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_EP] && side_q[ST_EP].sep_x == '0 && side_q[ST_EP].sep_y == '0 &&
      side_q[ST_EP].sep_z == '0 |->
      e_q[ST_EP][0] == '0 && e_q[ST_EP][1] == '0 && e_q[ST_EP][2] == '0)
    else $error("zero separation gave a nonzero direction");

endmodule

[verif/dpde_pair_force_checker.sv]
module dpde_pair_force_checker import dpde_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  pair_in_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  pair_out_t            out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CW-1:0]        cfg_data_i,
  output int                   fail_count_o,
  output int                   outstanding_o,
  output int                   results_o,
  output int                   in_range_o
);
  timeunit 1ns;
  timeprecision 1ps;

  mode_e         mode_q;
  logic [CW-1:0] cutoff_q, diss_q, noise_q, isdt_q;
  pair_out_t     expected_forces[$];

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return clip32((a * b) >>> FRAC_BITS);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic pair_out_t predict_pair(input pair_in_t p);
    longint sep[3], vel[3], dir[3], frc[3];
    logic [63:0] sumsq, root_len, m, q, num;
    longint w, bsum, g, ev, diss, nsq, fd, fn, t, fsum, ea, eb, ec, fe, n, n2;
    logic inr;
    pair_out_t r;
    sep[0] = p.sep_x; sep[1] = p.sep_y; sep[2] = p.sep_z;
    vel[0] = p.rel_vel_x; vel[1] = p.rel_vel_y; vel[2] = p.rel_vel_z;
    w = longint'(p.weight);
    bsum = longint'(p.inv_temp_first) + longint'(p.inv_temp_second);
    g = p.gauss;
    sumsq = 0;
    fe = 0;
    for (int i = 0; i < 3; i++) begin
      dir[i] = 0;
      frc[i] = 0;
      m = (sep[i] < 0) ? 64'(-sep[i]) : 64'(sep[i]);
      sumsq = sumsq + m * m;
    end
    inr = sumsq < 64'(cutoff_q) * 64'(cutoff_q);
    if (inr) begin
      root_len = floor_sqrt(sumsq);
      // zero separation keeps the direction at zero
      if (root_len != 0) begin
        for (int i = 0; i < 3; i++) begin
          m = (sep[i] < 0) ? 64'(-sep[i]) : 64'(sep[i]);
          q = (m << FRAC_BITS) / root_len;
          dir[i] = clip32((sep[i] < 0) ? -longint'(q) : longint'(q));
        end
      end
      t = 0;
      for (int i = 0; i < 3; i++) t += dir[i] * vel[i];
      ev = clip32(t >>> FRAC_BITS);
      if (mode_q == MODE_FIX_DISS) begin
        diss = longint'(diss_q);
        if (bsum == 0) begin
          nsq = 64'sd2147483647;
        end else begin
          num = (64'(diss_q) * 4) << FRAC_BITS;
          nsq = clip32(longint'(num / 64'(bsum)));
        end
        fn = clip32(longint'(floor_sqrt(64'(nsq) * 64'(w))));
        fn = qmul(g, fn);
        fn = qmul(fn, longint'(isdt_q));
        eb = qmul(nsq, w);
      end else begin
        n = longint'(noise_q);
        n2 = qmul(n, n);
        diss = clip32(longint'((64'(n2) * 64'(bsum)) >> (FRAC_BITS + 2)));
        t = qmul(n, g);
        t = qmul(t, longint'(floor_sqrt(64'(w) << FRAC_BITS)));
        fn = qmul(t, longint'(isdt_q));
        eb = qmul(n2, w);
      end
      t = qmul(diss, w);
      fd = clip32((-(t * ev)) >>> FRAC_BITS);
      ea = qmul(fd, ev);
      ec = qmul(fn, ev);
      fe = clip32((-ea - eb - ec) >>> 1);
      fsum = clip32(fd + fn);
      for (int i = 0; i < 3; i++) frc[i] = qmul(fsum, dir[i]);
    end
    r.force_x       = frc[0][31:0];
    r.force_y       = frc[1][31:0];
    r.force_z       = frc[2][31:0];
    r.energy_change = fe[31:0];
    r.in_range      = inr;
    r.apply_first   = inr & p.acts_first;
    r.apply_second  = inr & p.acts_second;
    return r;
  endfunction

  assign outstanding_o = expected_forces.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    pair_out_t want;
    if (!rst_ni) begin
      mode_q       <= MODE_FIX_DISS;
      cutoff_q     <= 31'd65536;
      diss_q       <= 31'd65536;
      noise_q      <= 31'd65536;
      isdt_q       <= 31'd65536;
      fail_count_o <= 0;
      results_o    <= 0;
      in_range_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:   mode_q   <= mode_e'(cfg_data_i[0]);
          CFG_CUTOFF: cutoff_q <= cfg_data_i;
          CFG_DISS:   diss_q   <= cfg_data_i;
          CFG_NOISE:  noise_q  <= cfg_data_i;
          CFG_ISDT:   isdt_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_forces.push_back(predict_pair(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        results_o  <= results_o + 1;
        in_range_o <= in_range_o + out_data_i.in_range;
        if (expected_forces.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result beat %p", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_forces.pop_front();
          if (want.force_x !== out_data_i.force_x || want.force_y !== out_data_i.force_y ||
              want.force_z !== out_data_i.force_z ||
              want.energy_change !== out_data_i.energy_change ||
              want.in_range !== out_data_i.in_range ||
              want.apply_first !== out_data_i.apply_first ||
              want.apply_second !== out_data_i.apply_second) begin
            if (fail_count_o < 10) begin
              $display("mismatch at beat %0d", results_o);
              $display("  expected %p", want);
              $display("  actual   %p", out_data_i);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

[verif/tb.sv]
module tb;
  import dpde_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 70;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  pair_in_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  pair_out_t            out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_MODE;
  logic [CW-1:0]        cfg_data_i = '0;
  int                   fail_count, outstanding, results, in_range_cnt;
  logic [CW-1:0]        cur_cutoff = 31'd65536;
  bit                   stim_done = 1'b0;

  always #5 clk_i = ~clk_i;

  dpde_pair_force dut (.*);

  dpde_pair_force_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .outstanding_o(outstanding),
    .results_o(results), .in_range_o(in_range_cnt)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [31:0] rand_near(input logic [31:0] lim);
    logic signed [31:0] v;
    v = $signed($urandom_range(0, lim));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [30:0] rand_mag31();
    return 31'($urandom) >> $urandom_range(0, 30);
  endfunction

  function automatic pair_in_t rand_pair();
    pair_in_t p;
    logic [31:0] lim;
    logic [319:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
    p = raw[$bits(pair_in_t)-1:0];
    // most pairs land inside the cutoff
    if ($urandom_range(0, 9) < 8) begin
      lim = 32'(cur_cutoff >> 1);
      p.sep_x = rand_near(lim);
      p.sep_y = rand_near(lim);
      p.sep_z = rand_near(lim);
      p.rel_vel_x = rand_near(32'h4_0000 >> $urandom_range(0, 8));
      p.rel_vel_y = rand_near(32'h4_0000 >> $urandom_range(0, 8));
      p.rel_vel_z = rand_near(32'h4_0000 >> $urandom_range(0, 8));
      p.weight = rand_mag31();
      p.inv_temp_first = rand_mag31() | 31'd1;
      p.inv_temp_second = rand_mag31() | 31'd1;
      p.gauss = rand_near(32'h4_0000);
    end
    return p;
  endfunction

  task automatic send_pair(input pair_in_t p);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (in_stall_o);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input cfg_idx_e idx, input logic [CW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == CFG_CUTOFF) cur_cutoff = val;
  endtask

  task automatic set_all(input mode_e m, input logic [CW-1:0] cut, input logic [CW-1:0] d,
                         input logic [CW-1:0] n, input logic [CW-1:0] s);
    wait_idle();
    write_reg(CFG_MODE, CW'(m));
    write_reg(CFG_CUTOFF, cut);
    write_reg(CFG_DISS, d);
    write_reg(CFG_NOISE, n);
    write_reg(CFG_ISDT, s);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic directed_pairs();
    pair_in_t p;
    p = '0;
    p.weight = 31'h1_0000; p.inv_temp_first = 31'h1_0000; p.inv_temp_second = 31'h1_0000;
    p.gauss = 32'sh1_0000; p.acts_first = 1'b1; p.acts_second = 1'b1;
    send_pair(p);                                   // zero separation
    p.sep_x = 32'sh4000; p.rel_vel_x = -32'sh2_0000;
    send_pair(p);
    p.inv_temp_first = '0; p.inv_temp_second = '0;  // zero temperature sum
    send_pair(p);
    p.inv_temp_first = '1; p.inv_temp_second = '1;
    p.weight = '1; p.gauss = 32'sh7FFF_FFFF;
    send_pair(p);
    p.gauss = 32'sh8000_0000; p.acts_first = 1'b0;
    send_pair(p);
    p.sep_x = 32'sh1_0000; p.acts_second = 1'b0;     // exactly on the reset cutoff
    send_pair(p);
    p.sep_x = 32'sh8000_0000; p.sep_y = 32'sh8000_0000; p.sep_z = 32'sh8000_0000;
    send_pair(p);
    p.sep_x = 32'sh7FFF_FFFF; p.sep_y = 32'sh7FFF_FFFF; p.sep_z = 32'sh7FFF_FFFF;
    send_pair(p);
    p.sep_x = -32'sh100; p.sep_y = 32'sh200; p.sep_z = -32'sh300;
    p.rel_vel_x = 32'sh7FFF_FFFF; p.rel_vel_y = 32'sh8000_0000; p.rel_vel_z = 32'sh7FFF_FFFF;
    p.acts_first = 1'b1;
    send_pair(p);
    p.weight = '0; p.gauss = '0;
    send_pair(p);
  endtask

  initial begin
    int r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    forever begin
      @(posedge clk_i);
      r = $urandom_range(0, 99);
      if (r < 30) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(20, 200)) @(posedge clk_i);
      end else if (r < 60) begin
        out_stall_i <= 1'b1;
        repeat (r < 57 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    directed_pairs();
    for (int k = 0; k < 250; k++) send_pair(rand_pair());
    set_all(MODE_FIX_NOISE, 31'h4_0000, 31'h2_0000, 31'h3_0000, 31'hA_0000);
    directed_pairs();
    for (int k = 0; k < 250; k++) send_pair(rand_pair());
    set_all(MODE_FIX_DISS, '1, '1, '0, '1);
    for (int k = 0; k < 250; k++) send_pair(rand_pair());
    set_all(MODE_FIX_NOISE, '1, '0, '1, 31'd1);
    for (int k = 0; k < 250; k++) send_pair(rand_pair());
    set_all(MODE_FIX_DISS, '0, '0, 31'h1_0000, '0);
    for (int k = 0; k < 100; k++) send_pair(rand_pair());
    set_all(MODE_FIX_NOISE, 31'h10_0000, 31'h1_0000, '0, 31'h2_0000);
    for (int k = 0; k < 250; k++) send_pair(rand_pair());
    set_all(MODE_FIX_DISS, rand_mag31(), rand_mag31(), rand_mag31(), rand_mag31());
    for (int k = 0; k < 200; k++) send_pair(rand_pair());
    set_all(MODE_FIX_NOISE, rand_mag31(), rand_mag31(), rand_mag31(), rand_mag31());
    for (int k = 0; k < 200; k++) send_pair(rand_pair());
    wait_idle();
    $display("covered %0d result beats, %0d in range, across 8 register settings",
             results, in_range_cnt);
    $display("both modes, zero and full-scale registers, stalls on both channels");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("status: fail");
    $finish;
  end
endmodule
